[design/rbdq_pkg.sv]
// ----------------------------------------------------------------------------
// rbdq_pkg: shared definitions for the ring buffer deque unit
// Field widths, command and status codes, and the control bundle that the
// top level hands to every storage cell.
// ----------------------------------------------------------------------------
package rbdq_pkg;

    // Fixed field widths.
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // Default number of stored words.
    localparam int DEPTH_DEF = 16;

    // Command codes.
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Per-cycle command to all cells of the chain.
    typedef struct packed {
        logic shift_in;   // every word moves one cell away from the rear
        logic shift_out;  // every word moves one cell toward the rear
        logic drop_last;  // the frontmost word is released
    } t_cell_ctrl;

endpackage

[design/rbdq_cell.sv]
// ----------------------------------------------------------------------------
// rbdq_cell: one storage cell of the deque chain
// Holds one word and its valid flag. On a push the cell takes its rear-side
// neighbor's contents, on a rear pop its front-side neighbor's contents, and
// on a front pop it lets go of its word if it is the frontmost one.
// ----------------------------------------------------------------------------
module rbdq_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rbdq_pkg::t_cell_ctrl         i_ctrl,
    input  logic [rbdq_pkg::DATA_W-1:0]  i_prev_data,
    input  logic                         i_prev_valid,
    input  logic [rbdq_pkg::DATA_W-1:0]  i_next_data,
    input  logic                         i_next_valid,
    output logic [rbdq_pkg::DATA_W-1:0]  o_data,
    output logic                         o_valid,
    output logic [rbdq_pkg::DATA_W-1:0]  o_front_data
);

    logic [rbdq_pkg::DATA_W-1:0] r_data;
    logic [rbdq_pkg::DATA_W-1:0] n_data;
    logic                        r_valid;
    logic                        n_valid;

    // Next contents from the chain command.
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.shift_in) begin
            n_data  = i_prev_data;
            n_valid = i_prev_valid;
        end else if (i_ctrl.shift_out) begin
            n_data  = i_next_data;
            n_valid = i_next_valid;
        end else if (i_ctrl.drop_last) begin
            n_valid = r_valid & i_next_valid;
        end
    end

    // The valid flag is control state; the word itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

    // Only the frontmost valid cell drives its word onto the front bus.
    assign o_front_data = (r_valid && !i_next_valid) ? r_data : '0;

endmodule

[design/ring_buffer_deque_unit.sv]
// ----------------------------------------------------------------------------
// ring_buffer_deque_unit: input-restricted deque of signed words
// Push at the rear, pop from the rear or pop from the front, one result item
// per command item carrying status, popped word and occupancy.
// ----------------------------------------------------------------------------
// The deque is a row of DEPTH cells with the rear word always in cell 0 and
// the front word in the highest valid cell. A push shifts every word one cell
// forward, a rear pop shifts every word one cell back, and a front pop only
// clears the frontmost valid flag, so each command is one parallel step of
// the chain. A command item is taken every cycle, and its result item is
// loaded into the output register when it is accepted; the result register takes a new
// item in the same cycle that the previous result leaves, and input ready
// drops only when a held result is not being taken. A push into a full deque
// answers full and a pop from an empty one answers empty with a zero word;
// neither changes the contents. There is no clearing pass after reset.
module ring_buffer_deque_unit #(
    parameter int DEPTH = rbdq_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic        [rbdq_pkg::OP_W-1:0]    i_opcode,
    input  logic signed [rbdq_pkg::DATA_W-1:0]  i_push_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic        [rbdq_pkg::ST_W-1:0]    o_status,
    output logic signed [rbdq_pkg::DATA_W-1:0]  o_pop_value,
    output logic        [CNT_W-1:0]             o_occupancy
);

    localparam int DW = rbdq_pkg::DATA_W;

    // Links between neighboring cells; link 0 feeds the rear, link DEPTH+1
    // closes the front end.
    logic [DW-1:0]          w_data  [DEPTH+2];
    logic                   w_valid [DEPTH+2];
    logic [DW-1:0]          w_front [DEPTH];
    rbdq_pkg::t_cell_ctrl   w_ctrl;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic [DW-1:0]          w_front_word;

    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_out_valid;
    logic [rbdq_pkg::ST_W-1:0]    r_status;
    logic [rbdq_pkg::ST_W-1:0]    n_status;
    logic [DW-1:0]                r_pop_value;
    logic [DW-1:0]                n_pop_value;
    logic [CNT_W-1:0]             r_occupancy;

    // Chain ends: a push brings a valid word into the rear, nothing enters
    // from beyond the front.
    assign w_data[0]        = i_push_value;
    assign w_valid[0]       = 1'b1;
    assign w_data[DEPTH+1]  = '0;
    assign w_valid[DEPTH+1] = 1'b0;

    // Row of cells; cell k sits on link k+1.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        rbdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_data  (w_data[k]),
            .i_prev_valid (w_valid[k]),
            .i_next_data  (w_data[k+2]),
            .i_next_valid (w_valid[k+2]),
            .o_data       (w_data[k+1]),
            .o_valid      (w_valid[k+1]),
            .o_front_data (w_front[k])
        );
    end

    // Gather the frontmost word; at most one cell drives a nonzero value.
    always_comb begin
        w_front_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_front_word = w_front_word | w_front[k];
        end
    end

    // Handshake: a new item may enter whenever the result register is free
    // or is being emptied in this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full  = w_valid[DEPTH];
    assign w_empty = !w_valid[1];

    // Command decode into the chain command, status, word and count.
    always_comb begin
        w_ctrl      = '0;
        n_status    = rbdq_pkg::ST_DONE;
        n_pop_value = '0;
        n_count     = r_count;
        case (i_opcode)
            rbdq_pkg::OP_PUSH_REAR: begin
                if (w_full) begin
                    n_status = rbdq_pkg::ST_FULL;
                end else begin
                    w_ctrl.shift_in = w_accept;
                    n_count         = r_count + CNT_W'(1);
                end
            end
            rbdq_pkg::OP_POP_REAR: begin
                if (w_empty) begin
                    n_status = rbdq_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.shift_out = w_accept;
                    n_pop_value      = w_data[1];
                    n_count          = r_count - CNT_W'(1);
                end
            end
            rbdq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = rbdq_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.drop_last = w_accept;
                    n_pop_value      = w_front_word;
                    n_count          = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = rbdq_pkg::ST_DONE;
            end
        endcase
    end

    // Occupancy count and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_pop_value <= n_pop_value;
            r_occupancy <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_pop_value = r_pop_value;
    assign o_occupancy = r_occupancy;

endmodule

[verif/tb_ring_buffer_deque_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque_unit: self-checking bench for the ring buffer deque
// Drives push, rear pop, front pop and unused commands through the valid and
// ready handshake, with random gaps on the command side and random stalls on
// the result side. Each result is checked field by field against a cycle-free
// model of the deque that is updated as commands are accepted.
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque_unit;

    localparam int DW = rbdq_pkg::DATA_W;
    localparam int OW = rbdq_pkg::OP_W;
    localparam int SW = rbdq_pkg::ST_W;
    localparam int DEPTH = rbdq_pkg::DEPTH_DEF;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [OW-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_COMMANDS = 750;

    typedef struct {
        logic        [OW-1:0] op;
        logic signed [DW-1:0] value;
        int                   gap;
        bit                   drain;
    } t_command;

    typedef struct {
        logic        [SW-1:0]    status;
        logic signed [DW-1:0]    word;
        logic        [CNT_W-1:0] count;
    } t_answer;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     cmd_valid = 1'b0;
    logic                     o_in_ready;
    logic        [OW-1:0]     cmd_opcode = '0;
    logic signed [DW-1:0]     cmd_value = '0;
    logic                     o_out_valid;
    logic                     rsp_ready = 1'b0;
    logic        [SW-1:0]     o_status;
    logic signed [DW-1:0]     o_pop_value;
    logic        [CNT_W-1:0]  o_occupancy;

    // Deque model state.
    logic signed [DW-1:0]     deque_store [DEPTH];
    int                       front_ptr = 0;
    int                       rear_ptr = 0;
    int                       fill_count = 0;

    t_command command_queue[$];
    t_answer  predicted_answers[$];
    bit       cmd_fire = 1'b0;
    int       idle_cycles = 0;
    int       stall_left = 0;
    int       rsp_cycles = 0;
    int       fail_count = 0;

    ring_buffer_deque_unit #(.DEPTH(DEPTH)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (cmd_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (cmd_opcode),
        .i_push_value (cmd_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (rsp_ready),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value),
        .o_occupancy  (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Random words with the sign and all-ones extremes mixed in.
    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: begin
                return 32'h7FFF_FFFF;
            end
            1: begin
                return 32'h8000_0000;
            end
            2: begin
                return 32'h0000_0000;
            end
            3: begin
                return 32'hFFFF_FFFF;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic void add_command(logic [OW-1:0] op, logic signed [DW-1:0] value);
        t_command c;
        c.op = op;
        c.value = value;
        c.gap = pick_gap();
        c.drain = 1'b0;
        command_queue.push_back(c);
    endfunction

    // Applies one accepted command to the deque model and returns its answer.
    function automatic t_answer apply_command(logic [OW-1:0] op,
                                              logic signed [DW-1:0] value);
        t_answer a;
        a.status = rbdq_pkg::ST_DONE;
        a.word = '0;
        case (op)
            rbdq_pkg::OP_PUSH_REAR: begin
                if (fill_count >= DEPTH) begin
                    a.status = rbdq_pkg::ST_FULL;
                end else begin
                    deque_store[rear_ptr] = value;
                    rear_ptr = (rear_ptr + 1) % DEPTH;
                    fill_count++;
                end
            end
            rbdq_pkg::OP_POP_REAR, rbdq_pkg::OP_POP_FRONT: begin
                if (fill_count == 0) begin
                    a.status = rbdq_pkg::ST_EMPTY;
                end else begin
                    if (op == rbdq_pkg::OP_POP_REAR) begin
                        rear_ptr = (rear_ptr + DEPTH - 1) % DEPTH;
                        a.word = deque_store[rear_ptr];
                    end else begin
                        a.word = deque_store[front_ptr];
                        front_ptr = (front_ptr + 1) % DEPTH;
                    end
                    fill_count--;
                    // An emptied deque starts over at slot zero.
                    if (fill_count == 0) begin
                        front_ptr = 0;
                        rear_ptr = 0;
                    end
                end
            end
            default: begin
            end
        endcase
        a.count = fill_count[CNT_W-1:0];
        return a;
    endfunction

    // Result checking and model update at the rising edge.
    always @(posedge i_clk) begin
        t_answer want;
        cmd_fire = i_rst_n && cmd_valid && o_in_ready;
        if (i_rst_n && o_out_valid && rsp_ready) begin
            if (predicted_answers.size() == 0) begin
                $error("unexpected result item: status %0d, pop_value %0d, occupancy %0d",
                       o_status, o_pop_value, o_occupancy);
                fail_count++;
            end else begin
                want = predicted_answers.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_pop_value !== want.word) begin
                    $error("pop_value: expected %0d, actual %0d", want.word, o_pop_value);
                    fail_count++;
                end
                if (o_occupancy !== want.count) begin
                    $error("occupancy: expected %0d, actual %0d", want.count, o_occupancy);
                    fail_count++;
                end
            end
        end
        if (cmd_fire) begin
            predicted_answers.push_back(apply_command(cmd_opcode, cmd_value));
        end
    end

    // Command driver: holds an item until it is taken, then honors the next
    // item's gap and, where asked, waits for all results to come back.
    always @(negedge i_clk) begin
        if (!i_rst_n || (cmd_valid && !cmd_fire)) begin
        end else if (command_queue.size() == 0) begin
            cmd_valid <= 1'b0;
        end else if (idle_cycles < command_queue[0].gap ||
                     (command_queue[0].drain && predicted_answers.size() != 0)) begin
            cmd_valid <= 1'b0;
            idle_cycles++;
        end else begin
            cmd_valid <= 1'b1;
            cmd_opcode <= command_queue[0].op;
            cmd_value <= command_queue[0].value;
            void'(command_queue.pop_front());
            idle_cycles = 0;
        end
    end

    // Result side stalls, with quiet stretches where no new stall is started.
    always @(negedge i_clk) begin
        rsp_cycles++;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
        end else begin
            rsp_ready <= 1'b1;
            if (((rsp_cycles / 256) % 4) != 1 && $urandom_range(0, 99) < 15) begin
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        t_command c;
        int phase_left;
        int push_bias;
        bit no_gaps;

        // Empty deque: both pops and the unused opcode.
        add_command(rbdq_pkg::OP_POP_REAR, 32'h1234_5678);
        add_command(rbdq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
        add_command(OP_UNUSED, 32'h8000_0000);
        // Emptying through the rear, then through the front.
        add_command(rbdq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF);
        add_command(rbdq_pkg::OP_POP_REAR, 32'h0);
        add_command(rbdq_pkg::OP_PUSH_REAR, 32'h8000_0000);
        add_command(rbdq_pkg::OP_POP_FRONT, 32'h0);
        add_command(rbdq_pkg::OP_PUSH_REAR, 32'h0000_0000);
        add_command(rbdq_pkg::OP_PUSH_REAR, 32'hFFFF_FFFF);
        add_command(OP_UNUSED, 32'h5A5A_A5A5);
        add_command(rbdq_pkg::OP_POP_FRONT, 32'h0);
        // Fill to the top, then push into a full deque.
        for (int i = 1; i < DEPTH; i++) begin
            add_command(rbdq_pkg::OP_PUSH_REAR, pick_value());
        end
        add_command(rbdq_pkg::OP_PUSH_REAR, 32'h0BAD_F00D);

        // Random phases that lean toward filling, draining or neither.
        phase_left = 0;
        push_bias = 50;
        no_gaps = 1'b0;
        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(15, 60);
                case ($urandom_range(0, 2))
                    0: begin
                        push_bias = 85;
                    end
                    1: begin
                        push_bias = 15;
                    end
                    default: begin
                        push_bias = 50;
                    end
                endcase
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            if ($urandom_range(0, 99) < 4) begin
                c.op = OP_UNUSED;
            end else if ($urandom_range(0, 99) < push_bias) begin
                c.op = rbdq_pkg::OP_PUSH_REAR;
            end else begin
                c.op = $urandom_range(0, 1) ? rbdq_pkg::OP_POP_REAR : rbdq_pkg::OP_POP_FRONT;
            end
            c.value = pick_value();
            c.gap = no_gaps ? 0 : pick_gap();
            c.drain = (n == 0) || ($urandom_range(0, 199) == 0);
            command_queue.push_back(c);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (command_queue.size() != 0 || cmd_valid) begin
            @(posedge i_clk);
        end
        while (predicted_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
